// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the keyed buffer pool
// clocked on clk_i, disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define KBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define KBP_ASSERT_IMP(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (con)) else $error(msg);

// next-cycle implication
`define KBP_ASSERT_NXT(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (con)) else $error(msg);

`endif

// ===== hw/rtl/kbp_pkg.sv =====
// shared types and constants for the keyed buffer pool
// used by kbp_cell and keyed_buffer_pool_top
`timescale 1ns / 1ps

package kbp_pkg;

  localparam int unsigned DEF_POOL_DEPTH = 64;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W_W  = 16;
  localparam int unsigned KEY_H_W  = 16;
  localparam int unsigned KEY_F_W  = 4;
  localparam int unsigned REL_W    = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned CNT_O_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_REL_ALL = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT       = 3'd0,
    ST_NEW       = 3'd1,
    ST_FULL      = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_IGNORED   = 3'd4,
    ST_ALL_FREED = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_SCAN,
    FSM_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_W_W-1:0] width;
    logic [KEY_H_W-1:0] height;
    logic [KEY_F_W-1:0] format;
  } key_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    key_t             key;
    logic [REL_W-1:0] rel;
    logic             rel_go;
    logic             free_all;
    logic             clear;
  } cell_ctrl_t;

  // search token walking down the row
  typedef struct packed {
    logic active;
    logic found;
    logic is_new;
  } token_t;

endpackage

// ===== hw/rtl/keyed_buffer_pool_top.sv =====
// keyed buffer pool: controller plus a row of POOL_DEPTH slot cells
// depends on kbp_pkg, kbp_cell and assert_macros.svh
//
//  channel | signals                                         | dir
//  in      | in_valid_i, in_stall_o, command_i, req_*_i,     | beat in
//          | release_slot_i                                  |
//  out     | out_valid_o, out_stall_i, status_o,             | beat out
//          | granted_slot_o, hit/miss/busy/filled_count_o    |
//
// one beat at a time; in_stall_o is high from accept until the result is taken
// acquire: EXEC, then SCAN while the search token moves one cell per cycle
// down the slot row, then RESP; release, release-all, clear: EXEC, then RESP
// the next beat can be accepted in the cycle after the result is taken
// reset clears busy and filled marks and counters at once, no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyed_buffer_pool_top #(
  parameter int unsigned POOL_DEPTH = kbp_pkg::DEF_POOL_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [kbp_pkg::CMD_W-1:0]      command_i,
  input  logic [kbp_pkg::KEY_W_W-1:0]    req_width_i,
  input  logic [kbp_pkg::KEY_H_W-1:0]    req_height_i,
  input  logic [kbp_pkg::KEY_F_W-1:0]    req_format_i,
  input  logic [kbp_pkg::REL_W-1:0]      release_slot_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [kbp_pkg::STATUS_W-1:0]   status_o,
  output logic [kbp_pkg::SLOT_W-1:0]     granted_slot_o,
  output logic [kbp_pkg::TOTAL_W-1:0]    hit_count_o,
  output logic [kbp_pkg::TOTAL_W-1:0]    miss_count_o,
  output logic [kbp_pkg::CNT_O_W-1:0]    busy_count_o,
  output logic [kbp_pkg::CNT_O_W-1:0]    filled_count_o
);
  import kbp_pkg::*;

  localparam int unsigned IDX_W = $clog2(POOL_DEPTH);
  localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);

  state_e               state_q, state_d;
  cmd_e                 cmd_q;
  key_t                 key_q;
  logic [REL_W-1:0]     rel_q;
  status_e              status_q, status_d;
  logic [IDX_W-1:0]     granted_q, granted_d;
  logic [TOTAL_W-1:0]   hit_q, hit_d, miss_q, miss_d;
  logic [CNT_W-1:0]     busy_q, busy_d, filled_q, filled_d;
  logic                 accept, res_load, rel_any;
  cell_ctrl_t           ctrl;
  token_t               tok [POOL_DEPTH+1];
  logic [IDX_W-1:0]     tok_idx [POOL_DEPTH+1];
  logic [POOL_DEPTH-1:0] rel_hit;

  assign accept = in_valid_i && !in_stall_o;
  assign rel_any = |rel_hit;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) state_d = FSM_EXEC;
      end
      FSM_EXEC: begin
        state_d = (cmd_q == CMD_ACQUIRE) ? FSM_SCAN : FSM_RESP;
      end
      FSM_SCAN: begin
        if (tok[POOL_DEPTH].active) state_d = FSM_RESP;
      end
      FSM_RESP: begin
        if (!out_stall_i) state_d = FSM_IDLE;
      end
    endcase
  end

  // outputs toward the cells and the handshake
  always_comb begin
    in_stall_o      = (state_q != FSM_IDLE);
    out_valid_o     = (state_q == FSM_RESP);
    ctrl.key        = key_q;
    ctrl.rel        = rel_q;
    ctrl.rel_go     = (state_q == FSM_EXEC) && (cmd_q == CMD_RELEASE);
    ctrl.free_all   = (state_q == FSM_EXEC) &&
                      ((cmd_q == CMD_REL_ALL) || (cmd_q == CMD_CLEAR));
    ctrl.clear      = (state_q == FSM_EXEC) && (cmd_q == CMD_CLEAR);
  end

  assign tok[0] = '{active: (state_q == FSM_EXEC) && (cmd_q == CMD_ACQUIRE),
                    found: 1'b0, is_new: 1'b0};
  assign tok_idx[0] = '0;

  // counters and result
  always_comb begin
    hit_d     = hit_q;
    miss_d    = miss_q;
    busy_d    = busy_q;
    filled_d  = filled_q;
    status_d  = status_q;
    granted_d = granted_q;
    res_load  = 1'b0;
    if (state_q == FSM_EXEC) begin
      granted_d = '0;
      unique case (cmd_q)
        CMD_ACQUIRE: begin
          granted_d = granted_q;
        end
        CMD_RELEASE: begin
          res_load = 1'b1;
          if (rel_any) begin
            status_d = ST_RELEASED;
            if (busy_q != '0) busy_d = busy_q - CNT_W'(1);
          end else begin
            status_d = ST_IGNORED;
          end
        end
        CMD_REL_ALL: begin
          res_load = 1'b1;
          status_d = ST_ALL_FREED;
          busy_d   = '0;
        end
        CMD_CLEAR: begin
          res_load = 1'b1;
          status_d = ST_CLEARED;
          busy_d   = '0;
          filled_d = '0;
          hit_d    = '0;
          miss_d   = '0;
        end
      endcase
    end else if ((state_q == FSM_SCAN) && tok[POOL_DEPTH].active) begin
      res_load = 1'b1;
      if (tok[POOL_DEPTH].found) begin
        granted_d = tok_idx[POOL_DEPTH];
        busy_d    = busy_q + CNT_W'(1);
        if (tok[POOL_DEPTH].is_new) begin
          status_d = ST_NEW;
          miss_d   = miss_q + TOTAL_W'(1);
          filled_d = filled_q + CNT_W'(1);
        end else begin
          status_d = ST_HIT;
          hit_d    = hit_q + TOTAL_W'(1);
        end
      end else begin
        status_d  = ST_FULL;
        granted_d = '0;
        miss_d    = miss_q + TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      hit_q    <= '0;
      miss_q   <= '0;
      busy_q   <= '0;
      filled_q <= '0;
    end else begin
      state_q  <= state_d;
      hit_q    <= hit_d;
      miss_q   <= miss_d;
      busy_q   <= busy_d;
      filled_q <= filled_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(command_i);
      key_q <= '{width: req_width_i, height: req_height_i, format: req_format_i};
      rel_q <= release_slot_i;
    end
    if (res_load) begin
      status_q  <= status_d;
      granted_q <= granted_d;
    end
  end

  for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
    kbp_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .tok_i     (tok[g]),
      .tok_idx_i (tok_idx[g]),
      .tok_o     (tok[g+1]),
      .tok_idx_o (tok_idx[g+1]),
      .rel_hit_o (rel_hit[g])
    );
  end

  assign status_o       = status_q;
  assign granted_slot_o = SLOT_W'(granted_q);
  assign hit_count_o    = hit_q;
  assign miss_count_o   = miss_q;
  assign busy_count_o   = CNT_O_W'(busy_q);
  assign filled_count_o = CNT_O_W'(filled_q);

  `KBP_ASSERT(a_busy_le_filled, busy_q <= filled_q, "busy count above filled count")
  `KBP_ASSERT(a_filled_le_depth, filled_q <= CNT_W'(POOL_DEPTH), "filled count above depth")
  `KBP_ASSERT_IMP(a_tail_in_scan, tok[POOL_DEPTH].active, state_q == FSM_SCAN, "token outside scan")
  `KBP_ASSERT_NXT(a_clear_zeroes, (state_q == FSM_EXEC) && (cmd_q == CMD_CLEAR), (hit_q == '0) && (miss_q == '0) && (filled_q == '0), "clear left counts")

endmodule

// ===== hw/rtl/kbp_cell.sv =====
// one pool slot: key, busy and filled marks, one stage of the search token
// depends on kbp_pkg
`timescale 1ns / 1ps

module kbp_cell #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  kbp_pkg::cell_ctrl_t     ctrl_i,
  input  kbp_pkg::token_t         tok_i,
  input  logic [IDX_W-1:0]        tok_idx_i,
  output kbp_pkg::token_t         tok_o,
  output logic [IDX_W-1:0]        tok_idx_o,
  output logic                    rel_hit_o
);
  import kbp_pkg::*;

  localparam bit               REACH  = (CELL_IDX < (1 << REL_W));
  localparam logic [REL_W-1:0] MY_REL = REL_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic             filled_q, filled_d;
  logic             busy_q, busy_d;
  key_t             key_q;
  token_t           tok_q, tok_d;
  logic [IDX_W-1:0] tok_idx_q, tok_idx_d;
  logic             match, claim_hit, claim_new;

  assign match     = filled_q && !busy_q && (key_q == ctrl_i.key);
  assign claim_hit = tok_i.active && !tok_i.found && match;
  assign claim_new = tok_i.active && !tok_i.found && !filled_q;
  assign rel_hit_o = REACH && ctrl_i.rel_go && filled_q && busy_q && (ctrl_i.rel == MY_REL);

  always_comb begin
    tok_d        = tok_i;
    tok_idx_d    = tok_idx_i;
    if (claim_hit || claim_new) begin
      tok_d.found  = 1'b1;
      tok_d.is_new = claim_new;
      tok_idx_d    = MY_IDX;
    end

    busy_d = busy_q;
    if (ctrl_i.clear || ctrl_i.free_all) begin
      busy_d = 1'b0;
    end else if (claim_hit || claim_new) begin
      busy_d = 1'b1;
    end else if (rel_hit_o) begin
      busy_d = 1'b0;
    end

    filled_d = filled_q;
    if (ctrl_i.clear) begin
      filled_d = 1'b0;
    end else if (claim_new) begin
      filled_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
      busy_q   <= 1'b0;
      tok_q    <= '0;
    end else begin
      filled_q <= filled_d;
      busy_q   <= busy_d;
      tok_q    <= tok_d;
    end
  end

  // key and token slot index carry no reset
  always_ff @(posedge clk_i) begin
    tok_idx_q <= tok_idx_d;
    if (claim_new) begin
      key_q <= ctrl_i.key;
    end
  end

  assign tok_o     = tok_q;
  assign tok_idx_o = tok_idx_q;

endmodule

// ===== tb/tb_keyed_buffer_pool_top.sv =====
// self-checking testbench for keyed_buffer_pool_top: directed and random pool commands
// depends on kbp_pkg and the pool RTL; a scoreboard class predicts each result beat
`timescale 1ns / 1ps

module tb_keyed_buffer_pool_top;
  import kbp_pkg::*;

  localparam int unsigned DEPTH = DEF_POOL_DEPTH;
  localparam int unsigned RANDOM_ITEMS = 1230;
  localparam int unsigned QUIET_ITEMS = 150;

  typedef struct {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    logic [CNT_O_W-1:0] busy;
    logic [CNT_O_W-1:0] filled;
  } pool_result_t;

  class pool_scoreboard;
    key_t               slot_key[DEPTH];
    bit                 slot_busy[DEPTH];
    int unsigned        filled;
    int unsigned        busy;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    pool_result_t       expected_q[$];
    int unsigned        errors;

    function void free_all();
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      busy = 0;
    endfunction

    function void note_request(cmd_e cmd, key_t key, logic [REL_W-1:0] rel);
      pool_result_t r;
      int           idx;
      idx = -1;
      r.slot = '0;
      case (cmd)
        CMD_ACQUIRE: begin
          for (int i = 0; i < filled; i++) begin
            if (!slot_busy[i] && slot_key[i] == key) begin
              idx = i;
              break;
            end
          end
          if (idx >= 0) begin
            slot_busy[idx] = 1'b1;
            hits++;
            busy++;
            r.status = ST_HIT;
            r.slot = idx[SLOT_W-1:0];
          end else begin
            misses++;
            if (filled < DEPTH) begin
              slot_key[filled] = key;
              slot_busy[filled] = 1'b1;
              r.status = ST_NEW;
              r.slot = filled[SLOT_W-1:0];
              filled++;
              busy++;
            end else begin
              r.status = ST_FULL;
            end
          end
        end
        CMD_RELEASE: begin
          if (rel < filled && slot_busy[rel]) begin
            slot_busy[rel] = 1'b0;
            if (busy > 0) busy--;
            r.status = ST_RELEASED;
          end else begin
            r.status = ST_IGNORED;
          end
        end
        CMD_REL_ALL: begin
          free_all();
          r.status = ST_ALL_FREED;
        end
        default: begin
          free_all();
          filled = 0;
          hits = '0;
          misses = '0;
          r.status = ST_CLEARED;
        end
      endcase
      r.hits = hits;
      r.misses = misses;
      r.busy = busy[CNT_O_W-1:0];
      r.filled = filled[CNT_O_W-1:0];
      expected_q = {expected_q, r};
    endfunction

    function void compare(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(pool_result_t got);
      pool_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result beat with no request outstanding, status %0d", got.status);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare("status", exp_r.status, got.status);
      compare("granted_slot", exp_r.slot, got.slot);
      compare("hit_count", exp_r.hits, got.hits);
      compare("miss_count", exp_r.misses, got.misses);
      compare("busy_count", exp_r.busy, got.busy);
      compare("filled_count", exp_r.filled, got.filled);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i = '0;
  logic [KEY_W_W-1:0]  req_width_i = '0;
  logic [KEY_H_W-1:0]  req_height_i = '0;
  logic [KEY_F_W-1:0]  req_format_i = '0;
  logic [REL_W-1:0]    release_slot_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   granted_slot_o;
  logic [TOTAL_W-1:0]  hit_count_o;
  logic [TOTAL_W-1:0]  miss_count_o;
  logic [CNT_O_W-1:0]  busy_count_o;
  logic [CNT_O_W-1:0]  filled_count_o;

  pool_scoreboard sb = new;
  bit             quiet = 1'b0;
  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_idle_pct = 0;
  int unsigned    hold_req = 0;

  keyed_buffer_pool_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .req_width_i    (req_width_i),
    .req_height_i   (req_height_i),
    .req_format_i   (req_format_i),
    .release_slot_i (release_slot_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .granted_slot_o (granted_slot_o),
    .hit_count_o    (hit_count_o),
    .miss_count_o   (miss_count_o),
    .busy_count_o   (busy_count_o),
    .filled_count_o (filled_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: check taken beats, stall in random bursts or one long hold-off
  initial begin
    pool_result_t got;
    int unsigned  stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.status = status_e'(status_o);
        got.slot = granted_slot_o;
        got.hits = hit_count_o;
        got.misses = miss_count_o;
        got.busy = busy_count_o;
        got.filled = filled_count_o;
        sb.check_result(got);
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end else if (stall_left == 0 && !quiet && rst_ni &&
                   $urandom_range(0, 99) < rx_idle_pct) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic key_t random_key();
    key_t k;
    k.width = 16'($urandom_range(0, 65535));
    k.height = 16'($urandom_range(0, 65535));
    k.format = 4'($urandom_range(0, 15));
    return k;
  endfunction

  function automatic key_t make_key(logic [15:0] w, logic [15:0] h, logic [3:0] f);
    key_t k;
    k.width = w;
    k.height = h;
    k.format = f;
    return k;
  endfunction

  task automatic send_beat(cmd_e cmd, key_t key, logic [REL_W-1:0] rel);
    if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    req_width_i <= key.width;
    req_height_i <= key.height;
    req_format_i <= key.format;
    release_slot_i <= rel;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(cmd, key, rel);
  endtask

  // drop valid so the last beat is not taken twice while waiting
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  function automatic logic [REL_W-1:0] pick_release();
    if (sb.filled > 0 && $urandom_range(0, 99) < 80)
      return REL_W'($urandom_range(0, sb.filled - 1));
    return REL_W'($urandom_range(0, 63));
  endfunction

  initial begin
    key_t        palette[6];
    key_t        key;
    cmd_e        cmd;
    int unsigned sent;
    int unsigned episode;
    int unsigned ep_len;
    int unsigned acq_pct;
    int unsigned rel_pct;
    int unsigned fresh_pct;
    int unsigned roll;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: key extremes, hits, ignored releases, release-all and clear
    send_beat(CMD_ACQUIRE, make_key(16'h0000, 16'h0000, 4'h0), 6'd0);
    send_beat(CMD_ACQUIRE, make_key(16'h0000, 16'h0000, 4'h0), 6'd63);
    send_beat(CMD_RELEASE, random_key(), 6'd0);
    send_beat(CMD_ACQUIRE, make_key(16'h0000, 16'h0000, 4'h0), 6'd0);
    send_beat(CMD_ACQUIRE, make_key(16'hffff, 16'hffff, 4'hf), 6'd0);
    send_beat(CMD_RELEASE, random_key(), 6'd2);
    send_beat(CMD_RELEASE, random_key(), 6'd2);
    send_beat(CMD_RELEASE, random_key(), 6'd63);
    send_beat(CMD_ACQUIRE, make_key(16'hffff, 16'hffff, 4'hf), 6'd0);
    send_beat(CMD_ACQUIRE, make_key(16'hffff, 16'hffff, 4'he), 6'd0);
    send_beat(CMD_ACQUIRE, make_key(16'hffff, 16'h0000, 4'hf), 6'd0);
    send_beat(CMD_REL_ALL, random_key(), 6'd0);
    send_beat(CMD_ACQUIRE, make_key(16'h0000, 16'h0000, 4'h0), 6'd0);
    send_beat(CMD_RELEASE, random_key(), 6'd1);
    send_beat(CMD_CLEAR, random_key(), 6'd0);
    send_beat(CMD_RELEASE, random_key(), 6'd0);
    send_beat(CMD_ACQUIRE, make_key(16'hffff, 16'hffff, 4'hf), 6'd0);
    send_beat(CMD_ACQUIRE, make_key(16'h5555, 16'haaaa, 4'ha), 6'h2a);
    send_beat(CMD_ACQUIRE, make_key(16'haaaa, 16'h5555, 4'h5), 6'h15);
    send_beat(CMD_RELEASE, random_key(), 6'h2a);
    send_beat(CMD_RELEASE, random_key(), 6'h01);

    sent = 0;
    episode = 0;
    while (sent < RANDOM_ITEMS) begin
      foreach (palette[i]) palette[i] = random_key();
      case ($urandom_range(0, 2))
        0: begin acq_pct = 55; rel_pct = 40; fresh_pct = 25; end
        1: begin acq_pct = 90; rel_pct = 9; fresh_pct = 80; end
        default: begin acq_pct = 50; rel_pct = 48; fresh_pct = 5; end
      endcase
      case ($urandom_range(0, 2))
        0: tx_idle_pct = 0;
        1: tx_idle_pct = 5;
        default: tx_idle_pct = 25;
      endcase
      case ($urandom_range(0, 2))
        0: rx_idle_pct = 0;
        1: rx_idle_pct = 5;
        default: rx_idle_pct = 25;
      endcase
      if (episode == 4 || $urandom_range(0, 3) == 0) wait_drained();
      if (episode == 2) hold_req = 300;
      ep_len = $urandom_range(40, 250);
      cmd = ($urandom_range(0, 1) == 0) ? CMD_CLEAR : CMD_REL_ALL;
      send_beat(cmd, random_key(), REL_W'($urandom_range(0, 63)));
      sent++;
      for (int n = 0; n < ep_len && sent < RANDOM_ITEMS; n++) begin
        if (sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < acq_pct) begin
          cmd = CMD_ACQUIRE;
        end else if (roll < acq_pct + rel_pct) begin
          cmd = CMD_RELEASE;
        end else begin
          cmd = ($urandom_range(0, 2) == 0) ? CMD_CLEAR : CMD_REL_ALL;
        end
        if (cmd == CMD_ACQUIRE && $urandom_range(0, 99) >= fresh_pct)
          key = palette[$urandom_range(0, 5)];
        else
          key = random_key();
        send_beat(cmd, key, pick_release());
        sent++;
      end
      episode++;
    end

    wait_drained();
    repeat (80) @(posedge clk_i);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/kbp_pkg.sv
hw/rtl/kbp_cell.sv
hw/rtl/keyed_buffer_pool_top.sv
tb/tb_keyed_buffer_pool_top.sv
